### sv/tlvrme_pkg.sv
`default_nettype none
package tlvrme_pkg;

  // Largest message kept; later bytes are dropped
  localparam int unsigned MaxReply = 2048;
  localparam int unsigned CountW   = $clog2(MaxReply + 1);

  localparam int unsigned IdxW  = 2;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned MaskW = 64;

  // Configuration register indexes
  localparam logic [IdxW-1:0] CFG_EXPECTED_MSG_ID = 2'd0;
  localparam logic [IdxW-1:0] CFG_WRITE_MODE      = 2'd1;
  localparam logic [IdxW-1:0] CFG_MASK_TYPE       = 2'd2;

  // Header layout and fixed values
  localparam logic [2:0] HdrPosFlags   = 3'd0;
  localparam logic [2:0] HdrPosTxnLo   = 3'd1;
  localparam logic [2:0] HdrPosTxnHi   = 3'd2;
  localparam logic [2:0] HdrPosIdLo    = 3'd3;
  localparam logic [2:0] HdrPosIdHi    = 3'd4;
  localparam logic [2:0] HdrPosLenLo   = 3'd5;
  localparam logic [7:0] HdrFlags      = 8'd2;
  localparam logic [7:0] HdrTxnLo      = 8'd1;
  localparam logic [7:0] HdrTxnHi      = 8'd0;
  localparam int unsigned HeaderLen    = 7;

  localparam logic [7:0]  ResultType    = 8'd2;
  localparam logic [15:0] ResultSize    = 16'd4;
  localparam logic [15:0] MaskSize      = 16'd8;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_FAILED   = 2'd2
  } status_t;

  typedef struct packed {
    status_t          status;
    logic [MaskW-1:0] band_mask;
    logic             mask_found;
  } rsp_t;

endpackage
`default_nettype wire

### sv/tlvrme_msg_if.sv
`default_nettype none
interface tlvrme_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

### sv/tlvrme_rsp_if.sv
`default_nettype none
interface tlvrme_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] band_mask;
  logic        mask_found;

  modport source (output valid, output status, output band_mask, output mask_found,
                  input ready);
  modport sink   (input valid, input status, input band_mask, input mask_found,
                  output ready);
endinterface
`default_nettype wire

### sv/tlv_reply_mask_extractor_core.sv
`default_nettype none
// Reply parser: takes a reply message one byte per transfer on msg (last_byte
// marks the final byte) and gives one transfer on result per message, at its
// final byte: status 0 accepted, 1 ignored (short message or foreign header),
// 2 failed; band_mask/mask_found carry the captured 8-byte mask TLV only on an
// accepted read-mode reply. The block takes one byte every cycle while
// msg.ready is high. A byte goes into an input register, is parsed in the
// following cycle, and its result (if any) sits in a two-entry result
// buffer: result valid rises once the parsed final byte moves from the input
// register into that buffer. msg.ready drops only while both result slots
// are held (or about to be) by untaken results; non-final bytes never produce
// results, so a stalled result side stops input only after two messages.
// Bytes past MaxReply are dropped. Configuration is written through cfg_we /
// cfg_index / cfg_data and must only change between messages.
module tlv_reply_mask_extractor_core
  import tlvrme_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  tlvrme_msg_if.sink           msg,
  tlvrme_rsp_if.source         result,
  input  wire logic            cfg_we,
  input  wire logic [IdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TYPE    = 3'd1,
    PH_SIZE_LO = 3'd2,
    PH_SIZE_HI = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_OK   = 2'd1,
    RES_BAD  = 2'd2
  } res_t;

  localparam logic [CountW-1:0] MaxCount = CountW'(MaxReply);
  localparam logic [CountW-1:0] MinCount = CountW'(HeaderLen);

  // Configuration registers
  logic [15:0] expected_msg_id;
  logic        write_mode;
  logic [7:0]  mask_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_msg_id <= 16'd52;
      write_mode      <= 1'b0;
      mask_type       <= 8'd21;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED_MSG_ID: expected_msg_id <= cfg_data;
        CFG_WRITE_MODE:      write_mode      <= cfg_data[0];
        CFG_MASK_TYPE:       mask_type       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Result buffer: head drives the port, tail is the skid slot
  rsp_t       head;
  rsp_t       tail;
  logic [1:0] count;
  logic       pop;
  logic       push;
  logic [1:0] occ;
  rsp_t       new_rsp;

  assign pop  = (count != 2'd0) && result.ready;
  assign push = s1_valid && s1_last;
  assign occ  = count + {1'b0, push};
  // A byte taken now may be a final byte that needs a slot once it leaves the input register
  assign msg.ready = pop ? (occ <= 2'd2) : (occ <= 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= msg.valid && msg.ready;
    end
    s1_byte <= msg.data_byte;
    s1_last <= msg.last_byte;
  end

  // Parser state
  logic [CountW-1:0] byte_count, byte_count_next;
  logic [16:0]       declared_total, declared_total_next;
  logic              header_mismatch, header_mismatch_next;
  phase_t            parse_phase, parse_phase_next;
  logic [7:0]        current_type, current_type_next;
  logic [15:0]       bytes_left, bytes_left_next;
  logic [3:0]        payload_index, payload_index_next;
  res_t              result_state, result_state_next;
  logic [MaskW-1:0]  mask_shift, mask_shift_next;
  logic              mask_seen, mask_seen_next;
  logic              failed, failed_next;
  logic              capturing, capturing_next;
  logic [15:0]       size_full;
  status_t           status;

  always_comb begin
    byte_count_next      = byte_count;
    declared_total_next  = declared_total;
    header_mismatch_next = header_mismatch;
    parse_phase_next     = parse_phase;
    current_type_next    = current_type;
    bytes_left_next      = bytes_left;
    payload_index_next   = payload_index;
    result_state_next    = result_state;
    mask_shift_next      = mask_shift;
    mask_seen_next       = mask_seen;
    failed_next          = failed;
    capturing_next       = capturing;
    size_full            = {s1_byte, bytes_left[7:0]};

    if (byte_count < MaxCount) begin
      byte_count_next = byte_count + 1'b1;
      if (parse_phase == PH_HEADER) begin
        // header phase only ever sees positions 0..6
        case (byte_count[2:0])
          HdrPosFlags: if (s1_byte != HdrFlags) header_mismatch_next = 1'b1;
          HdrPosTxnLo: if (s1_byte != HdrTxnLo) header_mismatch_next = 1'b1;
          HdrPosTxnHi: if (s1_byte != HdrTxnHi) header_mismatch_next = 1'b1;
          HdrPosIdLo:  if (s1_byte != expected_msg_id[7:0]) header_mismatch_next = 1'b1;
          HdrPosIdHi:  if (s1_byte != expected_msg_id[15:8]) header_mismatch_next = 1'b1;
          HdrPosLenLo: declared_total_next = {9'd0, s1_byte};
          default: begin
            declared_total_next = {1'b0, s1_byte, declared_total[7:0]} + 17'(HeaderLen);
            parse_phase_next    = PH_TYPE;
          end
        endcase
      end else if (!failed && !header_mismatch) begin
        case (parse_phase)
          PH_TYPE: begin
            current_type_next = s1_byte;
            parse_phase_next  = PH_SIZE_LO;
          end
          PH_SIZE_LO: begin
            bytes_left_next  = {8'd0, s1_byte};
            parse_phase_next = PH_SIZE_HI;
          end
          PH_SIZE_HI: begin
            bytes_left_next = size_full;
            capturing_next  = 1'b0;
            if (current_type == ResultType) begin
              if (size_full != ResultSize) failed_next = 1'b1;
              else result_state_next = RES_OK;
            end
            if (!write_mode && current_type == mask_type) begin
              if (size_full != MaskSize || mask_seen) begin
                failed_next = 1'b1;
              end else begin
                mask_seen_next  = 1'b1;
                capturing_next  = 1'b1;
                mask_shift_next = '0;
              end
            end
            payload_index_next = 4'd0;
            parse_phase_next   = (size_full == 16'd0) ? PH_TYPE : PH_PAYLOAD;
          end
          default: begin
            if (current_type == ResultType && s1_byte != 8'd0) result_state_next = RES_BAD;
            if (capturing && !payload_index[3]) begin
              for (int k = 0; k < 8; k++) begin
                if (payload_index[2:0] == 3'(k)) begin
                  mask_shift_next[8*k +: 8] = mask_shift[8*k +: 8] | s1_byte;
                end
              end
            end
            if (payload_index != 4'hF) payload_index_next = payload_index + 1'b1;
            bytes_left_next = bytes_left - 1'b1;
            if (bytes_left_next == 16'd0) begin
              parse_phase_next = PH_TYPE;
              capturing_next   = 1'b0;
            end
          end
        endcase
      end
    end

    // Verdict at the final byte
    if (byte_count_next < MinCount || header_mismatch_next) begin
      status = ST_IGNORED;
    end else if ({{(17-CountW){1'b0}}, byte_count_next} != declared_total_next ||
                 failed_next || parse_phase_next != PH_TYPE) begin
      status = ST_FAILED;
    end else if (result_state_next != RES_OK || (!write_mode && !mask_seen_next)) begin
      status = ST_FAILED;
    end else begin
      status = ST_ACCEPTED;
    end

    new_rsp.status = status;
    if (status == ST_ACCEPTED && !write_mode && mask_seen_next) begin
      new_rsp.band_mask  = mask_shift_next;
      new_rsp.mask_found = 1'b1;
    end else begin
      new_rsp.band_mask  = '0;
      new_rsp.mask_found = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_valid && s1_last)) begin
      byte_count      <= '0;
      declared_total  <= '0;
      header_mismatch <= 1'b0;
      parse_phase     <= PH_HEADER;
      current_type    <= '0;
      bytes_left      <= '0;
      payload_index   <= '0;
      result_state    <= RES_NONE;
      mask_shift      <= '0;
      mask_seen       <= 1'b0;
      failed          <= 1'b0;
      capturing       <= 1'b0;
    end else if (s1_valid) begin
      byte_count      <= byte_count_next;
      declared_total  <= declared_total_next;
      header_mismatch <= header_mismatch_next;
      parse_phase     <= parse_phase_next;
      current_type    <= current_type_next;
      bytes_left      <= bytes_left_next;
      payload_index   <= payload_index_next;
      result_state    <= result_state_next;
      mask_shift      <= mask_shift_next;
      mask_seen       <= mask_seen_next;
      failed          <= failed_next;
      capturing       <= capturing_next;
    end
  end

  // Result buffer update
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && pop) begin
        if (count == 2'd1) begin
          head <= new_rsp;
        end else begin
          head <= tail;
          tail <= new_rsp;
        end
      end else if (pop) begin
        head  <= tail;
        count <= count - 1'b1;
      end else if (push) begin
        if (count == 2'd0) head <= new_rsp;
        else tail <= new_rsp;
        count <= count + 1'b1;
      end
    end
  end

  assign result.valid      = (count != 2'd0);
  assign result.status     = head.status;
  assign result.band_mask  = head.band_mask;
  assign result.mask_found = head.mask_found;

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2) || pop)
    else $error("result buffer overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_mask_only_accepted: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_ACCEPTED |-> !result.mask_found &&
      result.band_mask == '0)
    else $error("mask reported on a non-accepted reply");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last |=> byte_count == '0 && parse_phase == PH_HEADER)
    else $error("parser not cleared after final byte");

endmodule
`default_nettype wire
